### sv/i128_pkg.sv
// Shared types, op codes and widths for the 128-bit ALU.
package i128_pkg;

    localparam int unsigned WordBitsDef = 128;
    localparam int unsigned HalfBits    = 64;
    localparam int unsigned FullBits    = 128;
    localparam int unsigned ShBits      = 7;
    localparam int unsigned QueueDepth  = 4;

    typedef enum logic [4:0] {
        OP_ADD = 5'd0,  OP_SUB = 5'd1,  OP_AND = 5'd2,  OP_OR  = 5'd3,
        OP_XOR = 5'd4,  OP_NOT = 5'd5,  OP_SHL = 5'd6,  OP_SAR = 5'd7,
        OP_ROL = 5'd8,  OP_ROR = 5'd9,  OP_MUL = 5'd10, OP_DIV = 5'd11,
        OP_LT  = 5'd12, OP_EQ  = 5'd13, OP_GT  = 5'd14, OP_LE  = 5'd15,
        OP_GE  = 5'd16
    } t_op;

    // Work class chosen by the front end
    typedef enum logic [1:0] {
        CL_FAST = 2'd0,
        CL_MUL  = 2'd1,
        CL_DIV  = 2'd2
    } t_class;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_MUL  = 2'd1,
        ST_DIV  = 2'd2,
        ST_DONE = 2'd3
    } t_state;

    // Result of one item
    typedef struct packed {
        logic [FullBits-1:0] res;
        logic                cmp;
        logic                derr;
    } t_res;

    // Classified item passed from front to back
    typedef struct packed {
        t_class              cls;
        logic [FullBits-1:0] a;
        logic [FullBits-1:0] b;
        logic                neg_q;
        t_res                fast;
    } t_job;

endpackage

### sv/int128_alu_mul_div.sv
// Top level of the 128-bit ALU: front end, item queue, mul/div back end.
// Add, logic, shift and compare items pass through the front register, a queue
// slot, then the result register; mul and div items are worked in the
// bit-serial back-end unit, which handles one such item at a time.
// Throughput: one fast item per cycle unless stalled; no new item while mul/div runs.
// Reset: synchronous active-low i_rst_n empties the queue and all stages.
module int128_alu_mul_div #(
    parameter int unsigned WORD_BITS = i128_pkg::WordBitsDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [4:0]  i_op,
    input  logic [63:0] i_operand_a_hi,
    input  logic [63:0] i_operand_a_lo,
    input  logic [63:0] i_operand_b_hi,
    input  logic [63:0] i_operand_b_lo,
    input  logic [6:0]  i_shift_amount,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_result_hi,
    output logic [63:0] o_result_lo,
    output logic        o_compare_true,
    output logic        o_divide_error
);
    logic           f_valid, q_stall, q_valid, b_stall;
    i128_pkg::t_job f_job, q_job;
    i128_pkg::t_res res;

    i128_front #(.WORD_BITS(WORD_BITS)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall,
        .i_op,
        .i_a({i_operand_a_hi, i_operand_a_lo}),
        .i_b({i_operand_b_hi, i_operand_b_lo}),
        .i_sh(i_shift_amount),
        .o_valid(f_valid), .i_stall(q_stall), .o_job(f_job)
    );

    i128_queue #(.DEPTH(i128_pkg::QueueDepth)) u_queue (
        .i_clk, .i_rst_n,
        .i_valid(f_valid), .o_stall(q_stall), .i_job(f_job),
        .o_valid(q_valid), .i_stall(b_stall), .o_job(q_job)
    );

    i128_back #(.WORD_BITS(WORD_BITS)) u_back (
        .i_clk, .i_rst_n,
        .i_valid(q_valid), .o_stall(b_stall), .i_job(q_job),
        .o_valid, .i_stall, .o_res(res)
    );

    assign o_result_hi    = res.res[127:64];
    assign o_result_lo    = res.res[63:0];
    assign o_compare_true = res.cmp;
    assign o_divide_error = res.derr;
endmodule

### sv/i128_front.sv
// Front end: decodes an item, computes the fast-class ops, preps mul/div.
module i128_front #(
    parameter int unsigned WORD_BITS = i128_pkg::WordBitsDef
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [4:0]                        i_op,
    input  logic [i128_pkg::FullBits-1:0]     i_a,
    input  logic [i128_pkg::FullBits-1:0]     i_b,
    input  logic [i128_pkg::ShBits-1:0]       i_sh,
    output logic                              o_valid,
    input  logic                              i_stall,
    output i128_pkg::t_job                    o_job
);
    localparam int unsigned W = WORD_BITS;

    logic           r_valid;
    i128_pkg::t_job r_job;
    i128_pkg::t_job n_job;

    logic [W-1:0] a, b, sum, dif, shl_r, sar_r, rol_r, ror_r, qa, qb;
    logic [2*W-1:0] rot2l, rot2r;
    logic [i128_pkg::ShBits-1:0] rmod, sar_n;
    logic lt, eq, sa, sb;

    assign a  = i_a[W-1:0];
    assign b  = i_b[W-1:0];
    assign sa = a[W-1];
    assign sb = b[W-1];
    assign sum = a + b;
    assign dif = a - b;
    assign eq  = (a == b);
    assign lt  = $signed(a) < $signed(b);
    assign qa  = sa ? (~a + W'(1)) : a;
    assign qb  = sb ? (~b + W'(1)) : b;

    // Rotate amount modulo the word width: amount is below 128, word at least 16
    function automatic logic [i128_pkg::ShBits-1:0] ShBitsMod(
        input logic [i128_pkg::ShBits-1:0] s);
        logic [i128_pkg::ShBits:0] t;
        t = {1'b0, s};
        for (int k = 0; k < 8; k++) begin
            if (t >= (i128_pkg::ShBits+1)'(W)) begin
                t = t - (i128_pkg::ShBits+1)'(W);
            end
        end
        return t[i128_pkg::ShBits-1:0];
    endfunction

    // Shifts and rotates
    always_comb begin
        rmod  = ShBitsMod(i_sh);
        sar_n = (32'(i_sh) >= W) ? i128_pkg::ShBits'(W - 1) : i_sh;
        shl_r = (32'(i_sh) >= W) ? '0 : (a << i_sh);
        sar_r = W'($signed(a) >>> sar_n);
        rot2l = {a, a} << rmod;
        rol_r = rot2l[2*W-1:W];
        rot2r = {a, a} >> rmod;
        ror_r = rot2r[W-1:0];
    end

    // Decode and fast-class results
    always_comb begin
        logic [W-1:0] r;
        r = '0;
        n_job = '0;
        n_job.cls = i128_pkg::CL_FAST;
        unique case (i_op)
            i128_pkg::OP_ADD: r = sum;
            i128_pkg::OP_SUB: r = dif;
            i128_pkg::OP_AND: r = a & b;
            i128_pkg::OP_OR:  r = a | b;
            i128_pkg::OP_XOR: r = a ^ b;
            i128_pkg::OP_NOT: r = ~a;
            i128_pkg::OP_SHL: r = shl_r;
            i128_pkg::OP_SAR: r = sar_r;
            i128_pkg::OP_ROL: r = rol_r;
            i128_pkg::OP_ROR: r = ror_r;
            i128_pkg::OP_MUL: n_job.cls = i128_pkg::CL_MUL;
            i128_pkg::OP_DIV: begin
                if (b == '0) begin
                    r = '1;
                    n_job.fast.derr = 1'b1;
                end else begin
                    n_job.cls = i128_pkg::CL_DIV;
                end
            end
            i128_pkg::OP_LT: n_job.fast.cmp = lt;
            i128_pkg::OP_EQ: n_job.fast.cmp = eq;
            i128_pkg::OP_GT: n_job.fast.cmp = !lt && !eq;
            i128_pkg::OP_LE: n_job.fast.cmp = lt || eq;
            i128_pkg::OP_GE: n_job.fast.cmp = !lt;
            default: r = '0;
        endcase
        n_job.fast.res = i128_pkg::FullBits'(r);
        // only divide works on magnitudes; Booth already yields the signed product
        n_job.neg_q = (i_op == i128_pkg::OP_DIV) && (sa ^ sb);
        if (i_op == i128_pkg::OP_DIV) begin
            n_job.a = i128_pkg::FullBits'(qa);
            n_job.b = i128_pkg::FullBits'(qb);
        end else begin
            n_job.a = i128_pkg::FullBits'(a);
            n_job.b = i128_pkg::FullBits'(b);
        end
    end

    // Output register with stall
    assign o_stall = r_valid && i_stall;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
        if (!o_stall && i_valid) begin
            r_job <= n_job;
        end
    end

    assign o_valid = r_valid;
    assign o_job   = r_job;
endmodule

### sv/i128_queue.sv
// Short FIFO of classified items between front and back.
module i128_queue #(
    parameter int unsigned DEPTH = i128_pkg::QueueDepth
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  i128_pkg::t_job i_job,
    output logic           o_valid,
    input  logic           i_stall,
    output i128_pkg::t_job o_job
);
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    i128_pkg::t_job r_mem [DEPTH];
    logic [AW-1:0]  r_wp, r_rp;
    logic [AW:0]    r_cnt;
    logic           push, pop;

    assign o_stall = (r_cnt == (AW+1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rp];
    assign push    = i_valid && !o_stall;
    assign pop     = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + AW'(1);
            end
            if (pop) begin
                r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + AW'(1);
            end
            r_cnt <= r_cnt + (AW+1)'(push) - (AW+1)'(pop);
        end
        if (push) begin
            r_mem[r_wp] <= i_job;
        end
    end
endmodule

### sv/i128_back.sv
// Back end: registers fast results; Booth multiply and restoring divide, one bit per cycle.
module i128_back #(
    parameter int unsigned WORD_BITS = i128_pkg::WordBitsDef
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  i128_pkg::t_job                i_job,
    output logic                          o_valid,
    input  logic                          i_stall,
    output i128_pkg::t_res                o_res
);
    localparam int unsigned W  = WORD_BITS;
    localparam int unsigned CW = $clog2(W + 1);

    i128_pkg::t_state r_state, n_state;
    logic [W-1:0]  r_x, r_y, r_acc, r_rem;
    logic          r_prev, r_negq;
    logic [CW-1:0] r_cnt;
    i128_pkg::t_res r_out;
    logic          r_ovalid;

    logic          take, busy_free, out_free;
    logic [W-1:0]  rem_sh, rem_sub, booth;
    logic          fits;

    assign out_free = !r_ovalid || !i_stall;
    assign busy_free = (r_state == i128_pkg::ST_IDLE);
    assign o_stall  = !(busy_free && out_free);
    assign take     = i_valid && !o_stall;

    // Divide step: shift in next dividend bit, subtract when it fits
    assign rem_sh  = {r_rem[W-2:0], r_x[W-1]};
    assign fits    = !r_rem[W-1] && (rem_sh >= r_y) || r_rem[W-1];
    assign rem_sub = rem_sh - r_y;
    // Booth step on multiplier bit pair
    always_comb begin
        unique case ({r_x[0], r_prev})
            2'b10:   booth = r_acc - r_y;
            2'b01:   booth = r_acc + r_y;
            default: booth = r_acc;
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            i128_pkg::ST_IDLE: begin
                if (take && i_job.cls == i128_pkg::CL_MUL) begin
                    n_state = i128_pkg::ST_MUL;
                end else if (take && i_job.cls == i128_pkg::CL_DIV) begin
                    n_state = i128_pkg::ST_DIV;
                end
            end
            i128_pkg::ST_MUL, i128_pkg::ST_DIV: begin
                if (r_cnt == CW'(W - 1)) begin
                    n_state = i128_pkg::ST_DONE;
                end
            end
            i128_pkg::ST_DONE: begin
                if (out_free) begin
                    n_state = i128_pkg::ST_IDLE;
                end
            end
            default: n_state = i128_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= i128_pkg::ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (take && i_job.cls == i128_pkg::CL_FAST) begin
                r_ovalid <= 1'b1;
            end else if (r_state == i128_pkg::ST_DONE && out_free) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
        // Operand load
        if (take) begin
            r_x    <= i_job.a[W-1:0];
            r_y    <= i_job.b[W-1:0];
            r_acc  <= '0;
            r_rem  <= '0;
            r_prev <= 1'b0;
            r_negq <= i_job.neg_q;
            r_cnt  <= '0;
            if (i_job.cls == i128_pkg::CL_FAST) begin
                r_out <= i_job.fast;
            end
        end
        // Booth: product low word builds as the multiplicand shifts left
        if (r_state == i128_pkg::ST_MUL) begin
            r_acc  <= booth;
            r_y    <= r_y << 1;
            r_prev <= r_x[0];
            r_x    <= r_x >> 1;
            r_cnt  <= r_cnt + CW'(1);
        end
        if (r_state == i128_pkg::ST_DIV) begin
            r_rem <= fits ? rem_sub : rem_sh;
            r_acc <= {r_acc[W-2:0], fits};
            r_x   <= r_x << 1;
            r_cnt <= r_cnt + CW'(1);
        end
        if (r_state == i128_pkg::ST_DONE && out_free) begin
            r_out.cmp  <= 1'b0;
            r_out.derr <= 1'b0;
            r_out.res  <= i128_pkg::FullBits'(r_negq ? (~r_acc + W'(1)) : r_acc);
        end
    end

    assign o_valid = r_ovalid;
    assign o_res   = r_out;
endmodule
